// ----- rtl/core/rmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mixer package
// Shared item types, command codes, register indexes and the Q15 trig ROM.
// ----------------------------------------------------------------------------
package rmm_pkg;

   // Rotor limit: the span of the trig ROM and of the 3-bit rotor fields
   localparam int unsigned MAX_ROTORS  = 8;
   localparam int unsigned ROTOR_W     = 3;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [15:0] ONE_Q15  = 16'd32768;
   localparam logic [15:0] HALF_Q15 = 16'd16384;
   // 0.3 in Q15
   localparam logic signed [15:0] MIX_GAIN_Q15 = 16'sd9830;

   // Input actions
   localparam logic [1:0] ACT_APPLY   = 2'd0;
   localparam logic [1:0] ACT_KILL    = 2'd1;
   localparam logic [1:0] ACT_RESTORE = 2'd2;
   localparam logic [1:0] ACT_TRIM    = 2'd3;

   // Classified operations handed from front to back
   localparam logic [2:0] OP_APPLY_MIX = 3'd0;
   localparam logic [2:0] OP_APPLY_FW  = 3'd1;
   localparam logic [2:0] OP_KILL      = 3'd2;
   localparam logic [2:0] OP_RESTORE   = 3'd3;
   localparam logic [2:0] OP_TRIM      = 3'd4;
   localparam logic [2:0] OP_BAD       = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_NUM_ROTORS = 2'd0;
   localparam logic [1:0] CSR_HOVER      = 2'd1;
   localparam logic [1:0] CSR_FIXED_WING = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        throttle_cmd;
      logic signed [15:0] pitch_cmd;
      logic signed [15:0] roll_cmd;
      logic signed [15:0] yaw_cmd;
      logic [2:0]         target_rotor;
   } req_type;

   typedef struct packed {
      logic [2:0]  rotor_number;
      logic [15:0] rotor_throttle;
      logic        rotor_killed;
      logic        index_ok;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        thr;     // saturated throttle, or trim value
      logic [15:0]        hov;     // saturated hover throttle
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic signed [15:0] yaw;
      logic [ROTOR_W-1:0] first;   // first rotor touched
      logic [COUNT_W-1:0] count;   // number of results
      logic [ROTOR_W-1:0] n_sel;   // rotor count minus one, ROM row
   } cmd_type;

   // round(32768*cos(2*pi*i/n)), row n-1, column i
   localparam logic signed [16:0] COS_ROM [0:7][0:7] = '{
      '{17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd32768, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd32768, -17'sd16384, -17'sd16384, 17'sd0, 17'sd0, 17'sd0, 17'sd0,
        17'sd0},
      '{17'sd32768, 17'sd0, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd32768, 17'sd10126, -17'sd26510, -17'sd26510, 17'sd10126, 17'sd0,
        17'sd0, 17'sd0},
      '{17'sd32768, 17'sd16384, -17'sd16384, -17'sd32768, -17'sd16384,
        17'sd16384, 17'sd0, 17'sd0},
      '{17'sd32768, 17'sd20431, -17'sd7292, -17'sd29523, -17'sd29523,
        -17'sd7292, 17'sd20431, 17'sd0},
      '{17'sd32768, 17'sd23170, 17'sd0, -17'sd23170, -17'sd32768, -17'sd23170,
        17'sd0, 17'sd23170}
   };

   // round(32768*sin(2*pi*i/n)), row n-1, column i
   localparam logic signed [16:0] SIN_ROM [0:7][0:7] = '{
      '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd28378, -17'sd28378, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd32768, 17'sd0, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd31164, 17'sd19261, -17'sd19261, -17'sd31164, 17'sd0,
        17'sd0, 17'sd0},
      '{17'sd0, 17'sd28378, 17'sd28378, 17'sd0, -17'sd28378, -17'sd28378,
        17'sd0, 17'sd0},
      '{17'sd0, 17'sd25619, 17'sd31946, 17'sd14218, -17'sd14218, -17'sd31946,
        -17'sd25619, 17'sd0},
      '{17'sd0, 17'sd23170, 17'sd32768, 17'sd23170, 17'sd0, -17'sd23170,
        -17'sd32768, -17'sd23170}
   };

endpackage

// ----- rtl/core/multirotor_motor_mixer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multirotor motor mixer
// Mixes throttle and stick items into per-rotor Q15 throttles, with kill,
// restore and trim of individual rotors.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per action (apply, kill, restore, trim). An item is
//            taken on a clock edge with req_valid high and req_stall low.
//   rsp_*  : one result per rotor for apply and trim (rotors 0..n-1, last
//            set on the final one), one result for kill and restore.
//   csr_*  : register writes (rotor count, hover throttle, fixed-wing mode);
//            csr_ready is always high. Write only while the block is idle.
//            Writing the rotor count clears all throttles and kill marks.
// Timing: a two-entry command queue sits between the front end and the
//   mixing back end. The back end walks one rotor per cycle, unless
//   rsp_stall holds the result register, through a three-stage multiply
//   pipeline, and takes the next command only once the pipeline drains;
//   each result leaves stage 3 through the registered result output.
// Stall: rsp_stall with a result pending freezes the whole mixing pipeline
//   and the result register; the queue keeps taking items until it fills.
// Reset: synchronous, active high; registers return to four rotors, half
//   hover throttle, rotor mixing, all throttles zero and no kill marks.
// ----------------------------------------------------------------------------
module multirotor_motor_mixer_unit
   import rmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [3:0]  num_rotors_ff;
   logic [15:0] hover_ff;
   logic        fixed_wing_ff;
   logic        csr_write;
   logic        clear_store;

   logic        push_valid;
   logic        push_ready;
   cmd_type     push_data;
   logic        pop_valid;
   logic        pop_ready;
   cmd_type     pop_data;

   // Configuration registers: always ready
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign clear_store = csr_write && (csr_index == CSR_NUM_ROTORS);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rotors_ff <= 4'd4;
         hover_ff      <= HALF_Q15;
         fixed_wing_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_ROTORS: num_rotors_ff <= csr_wdata[3:0];
            CSR_HOVER:      hover_ff      <= csr_wdata;
            CSR_FIXED_WING: fixed_wing_ff <= csr_wdata[0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Classify incoming items
   rmm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .num_rotors      (num_rotors_ff),
      .hover_throttle  (hover_ff),
      .fixed_wing_mode (fixed_wing_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // Decouple front end from the mixing back end
   rmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Walk the rotors, update state, drive results
   rmm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clear_store (clear_store),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/core/rmm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mixer front end
// Accept request items, saturate throttles and classify each into a command.
// ----------------------------------------------------------------------------
module rmm_front
   import rmm_pkg::*;
(
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic [3:0]  num_rotors,
   input  logic [15:0] hover_throttle,
   input  logic        fixed_wing_mode,
   output logic        push_valid,
   input  logic        push_ready,
   output cmd_type     push_data
);

   logic [COUNT_W-1:0] n_eff;
   logic [15:0]        thr_sat;
   logic [15:0]        hov_sat;
   logic               target_ok;

   assign n_eff     = (num_rotors > COUNT_W'(MAX_ROTORS)) ? COUNT_W'(MAX_ROTORS)
                                                          : num_rotors;
   assign thr_sat   = (req_data.throttle_cmd > ONE_Q15) ? ONE_Q15
                                                        : req_data.throttle_cmd;
   assign hov_sat   = (hover_throttle > ONE_Q15) ? ONE_Q15 : hover_throttle;
   assign target_ok = COUNT_W'(req_data.target_rotor) < n_eff;

   assign push_valid = req_valid;
   assign req_stall  = !push_ready;

   always_comb begin
      push_data       = '0;
      push_data.thr   = thr_sat;
      push_data.hov   = hov_sat;
      push_data.pitch = req_data.pitch_cmd;
      push_data.roll  = req_data.roll_cmd;
      push_data.yaw   = req_data.yaw_cmd;
      push_data.n_sel = ROTOR_W'(n_eff - COUNT_W'(1));
      case (req_data.action)
         ACT_APPLY: begin
            push_data.op    = fixed_wing_mode ? OP_APPLY_FW : OP_APPLY_MIX;
            push_data.first = '0;
            push_data.count = n_eff;
         end
         ACT_TRIM: begin
            push_data.op    = OP_TRIM;
            push_data.thr   = fixed_wing_mode ? HALF_Q15 : hov_sat;
            push_data.first = '0;
            push_data.count = n_eff;
         end
         ACT_KILL, ACT_RESTORE: begin
            if (!target_ok) begin
               push_data.op = OP_BAD;
            end else if (req_data.action == ACT_KILL) begin
               push_data.op = OP_KILL;
            end else begin
               push_data.op = OP_RESTORE;
            end
            push_data.first = req_data.target_rotor;
            push_data.count = COUNT_W'(1);
         end
         default: begin
            push_data.op    = OP_BAD;
            push_data.first = req_data.target_rotor;
            push_data.count = COUNT_W'(1);
         end
      endcase
   end

endmodule

// ----- rtl/core/rmm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mixer command queue
// Short FIFO of classified commands between front end and back end.
// ----------------------------------------------------------------------------
module rmm_queue
   import rmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/rmm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mixer back end
// Sequence the rotors of one command through the mixing pipeline, update
// the throttle store and kill marks, and drive the result register.
// ----------------------------------------------------------------------------
module rmm_back
   import rmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    clear_store,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam int unsigned SUM_W = 49;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd536870912);

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [31:0]         base_ff, base_in;
   logic [ROTOR_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]  left_ff, left_in;

   logic                adv;
   logic                issue;

   // stage 1: stick products
   logic                s1_v_ff, s1_v_in;
   logic [ROTOR_W-1:0]  s1_idx_ff;
   logic                s1_last_ff;
   logic signed [32:0]  s1_pp_ff, s1_pp_in;
   logic signed [32:0]  s1_rp_ff, s1_rp_in;
   logic signed [16:0]  s1_yaw_ff, s1_yaw_in;
   // stage 2: mix sum
   logic                s2_v_ff;
   logic [ROTOR_W-1:0]  s2_idx_ff;
   logic                s2_last_ff;
   logic signed [33:0]  s2_mix_ff, s2_mix_in;
   // stage 3: gained mix
   logic                s3_v_ff;
   logic [ROTOR_W-1:0]  s3_idx_ff;
   logic                s3_last_ff;
   logic signed [SUM_W-1:0] s3_scaled_ff, s3_scaled_in;

   logic signed [SUM_W-1:0] sum45;
   logic signed [SUM_W-1:0] rounded;
   logic [18:0]         quot;
   logic [15:0]         mixed;

   logic [15:0]         store_ff [MAX_ROTORS];
   logic [MAX_ROTORS-1:0] kill_ff;
   logic [15:0]         cur_thr;
   logic                cur_kill;
   logic [15:0]         new_thr;
   logic                new_kill;
   logic                new_ok;
   logic                wr_en;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = state_ff == ST_IDLE;
   assign issue     = (state_ff == ST_RUN) && adv && (left_ff != '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: take one command, walk its rotors, wait for the pipe to empty
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in  = pop_data;
               base_in = (32'(pop_data.thr) * 32'(pop_data.hov)) << 1;
               idx_in  = pop_data.first;
               left_in = pop_data.count;
               if (pop_data.count != '0) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               idx_in  = idx_ff + ROTOR_W'(1);
               left_in = left_ff - COUNT_W'(1);
               if (left_ff == COUNT_W'(1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Mixing datapath
   always_comb begin
      s1_v_in   = issue;
      s1_pp_in  = 33'(cmd_ff.pitch) * 33'(COS_ROM[cmd_ff.n_sel][idx_ff]);
      s1_rp_in  = 33'(cmd_ff.roll) * 33'(SIN_ROM[cmd_ff.n_sel][idx_ff]);
      s1_yaw_in = idx_ff[0] ? -17'(cmd_ff.yaw) : 17'(cmd_ff.yaw);
      s2_mix_in = 34'(s1_pp_ff) + 34'(s1_rp_ff) + (34'(s1_yaw_ff) <<< 15);
      s3_scaled_in = SUM_W'(s2_mix_ff) * SUM_W'(MIX_GAIN_Q15);

      sum45   = $signed({2'b00, base_ff, 15'd0}) + s3_scaled_ff;
      rounded = sum45 + ROUND_HALF;
      quot    = rounded[48:30];
      if (sum45[SUM_W-1] || (sum45 == '0)) begin
         mixed = '0;
      end else if (quot > 19'(ONE_Q15)) begin
         mixed = ONE_Q15;
      end else begin
         mixed = quot[15:0];
      end
   end

   // Final stage: apply the operation to the addressed rotor
   always_comb begin
      cur_thr  = store_ff[s3_idx_ff];
      cur_kill = kill_ff[s3_idx_ff];
      new_thr  = cur_thr;
      new_kill = cur_kill;
      new_ok   = 1'b1;
      case (cmd_ff.op)
         OP_APPLY_MIX: begin
            new_thr = cur_kill ? '0 : mixed;
         end
         OP_APPLY_FW: begin
            if (cur_kill) begin
               new_thr = '0;
            end else if (s3_idx_ff == '0) begin
               new_thr = cmd_ff.thr;
            end
         end
         OP_KILL: begin
            new_thr  = '0;
            new_kill = 1'b1;
         end
         OP_RESTORE, OP_TRIM: begin
            new_thr  = cmd_ff.thr;
            new_kill = 1'b0;
         end
         default: begin
            // out-of-range index: report zeros, touch nothing
            new_thr  = '0;
            new_kill = 1'b0;
            new_ok   = 1'b0;
         end
      endcase
      wr_en = s3_v_ff && adv && new_ok;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         rsp_valid_in                = s3_v_ff;
         rsp_data_in.rotor_number    = s3_idx_ff;
         rsp_data_in.rotor_throttle  = new_thr;
         rsp_data_in.rotor_killed    = new_kill;
         rsp_data_in.index_ok        = new_ok;
         rsp_data_in.last            = s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         left_ff      <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         left_ff  <= left_in;
         if (adv) begin
            s1_v_ff <= s1_v_in;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
      if (adv) begin
         s1_idx_ff    <= idx_ff;
         s1_last_ff   <= left_ff == COUNT_W'(1);
         s1_pp_ff     <= s1_pp_in;
         s1_rp_ff     <= s1_rp_in;
         s1_yaw_ff    <= s1_yaw_in;
         s2_idx_ff    <= s1_idx_ff;
         s2_last_ff   <= s1_last_ff;
         s2_mix_ff    <= s2_mix_in;
         s3_idx_ff    <= s2_idx_ff;
         s3_last_ff   <= s2_last_ff;
         s3_scaled_ff <= s3_scaled_in;
      end
   end

   // Throttle store and kill marks
   always_ff @(posedge clock) begin
      if (reset || clear_store) begin
         for (int i = 0; i < int'(MAX_ROTORS); i++) begin
            store_ff[i] <= '0;
         end
         kill_ff <= '0;
      end else if (wr_en) begin
         store_ff[s3_idx_ff] <= new_thr;
         kill_ff[s3_idx_ff]  <= new_kill;
      end
   end

`ifndef SYNTHESIS
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.index_ok |-> rsp_data_ff.last)
      else $error("out-of-range result not marked last");

   a_killed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rotor_killed |-> rsp_data_ff.rotor_throttle == '0)
      else $error("killed rotor reported with nonzero throttle");

   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.rotor_throttle <= ONE_Q15)
      else $error("rotor throttle above 1.0");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !s1_v_ff && !s2_v_ff && !s3_v_ff)
      else $error("pipeline busy while sequencer idle");

   a_issue_run: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !$past(s1_v_ff) |-> $past(state_ff) == ST_RUN)
      else $error("rotor issued outside run state");
`endif

endmodule

// ----- tb/tb_multirotor_motor_mixer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mixer testbench
// Drives action items into the mixer under random idling on both channels and
// compares every rotor report against a scoreboard that models the rotor
// throttles, kill marks and Q15 mixing arithmetic of the block.
// ----------------------------------------------------------------------------
module tb_multirotor_motor_mixer_unit;
   import rmm_pkg::*;

   // Track mixer state and queue the rotor reports each item should produce.
   class rotor_report_board;
      logic [3:0]  rotor_cfg;
      logic [15:0] hover_cfg;
      logic        fw_cfg;
      logic [15:0] rotor_thr [MAX_ROTORS];
      logic        rotor_dead [MAX_ROTORS];
      rsp_type     reports_due [$];
      int          errors;

      function new();
         rotor_cfg = 4'd4;
         hover_cfg = HALF_Q15;
         fw_cfg    = 1'b0;
         errors    = 0;
         clear_rotors();
      endfunction

      function void clear_rotors();
         for (int i = 0; i < MAX_ROTORS; i++) begin
            rotor_thr[i]  = '0;
            rotor_dead[i] = 1'b0;
         end
      endfunction

      // A rotor count write also wipes every throttle and kill mark
      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_NUM_ROTORS: begin
               rotor_cfg = val[3:0];
               clear_rotors();
            end
            CSR_HOVER:      hover_cfg = val;
            CSR_FIXED_WING: fw_cfg = val[0];
            default: ;
         endcase
      endfunction

      function int live_rotors();
         return (rotor_cfg > MAX_ROTORS) ? MAX_ROTORS : int'(rotor_cfg);
      endfunction

      function logic [15:0] sat_q15(logic [15:0] v);
         return (v > ONE_Q15) ? ONE_Q15 : v;
      endfunction

      // round(32768 * cos or sin of 2*pi*i/n), ties away from zero
      function longint trig_q15(bit want_sin, int n, int i);
         real ang, x;
         ang = 2.0 * 3.14159265358979 * i / n;
         x = 32768.0 * (want_sin ? $sin(ang) : $cos(ang));
         return (x >= 0.0) ? longint'($rtoi(x + 0.5)) : -longint'($rtoi(0.5 - x));
      endfunction

      function logic [15:0] mix_throttle(int n, int i, longint base30,
                                         longint p, longint r, longint y);
         longint yaw, mix30, sum45, q;
         yaw   = i[0] ? -y : y;
         mix30 = p * trig_q15(1'b0, n, i) + r * trig_q15(1'b1, n, i) + yaw * 32768;
         // 9830 is the 0.3 gain in Q15; sum is Q45
         sum45 = base30 * 32768 + mix30 * 9830;
         if (sum45 <= 0)
            return '0;
         q = (sum45 + 64'sd536870912) >>> 30;
         return (q > 32768) ? ONE_Q15 : q[15:0];
      endfunction

      function rsp_type report(int rotor, logic [15:0] thr, logic dead, logic ok,
                               logic fin);
         rsp_type r;
         r.rotor_number   = rotor[2:0];
         r.rotor_throttle = thr;
         r.rotor_killed   = dead;
         r.index_ok       = ok;
         r.last           = fin;
         return r;
      endfunction

      function void queue_all(int n);
         for (int i = 0; i < n; i++)
            reports_due.push_back(report(i, rotor_thr[i], rotor_dead[i], 1'b1,
                                         i == n - 1));
      endfunction

      function void note_item(req_type it);
         int          n, tgt;
         logic [15:0] thr, hov;
         longint      base30;
         n   = live_rotors();
         thr = sat_q15(it.throttle_cmd);
         hov = sat_q15(hover_cfg);
         tgt = int'(it.target_rotor);
         case (it.action)
            ACT_APPLY: begin
               if (fw_cfg) begin
                  if (n > 0)
                     rotor_thr[0] = thr;
               end else begin
                  base30 = 2 * longint'(thr) * longint'(hov);
                  for (int i = 0; i < n; i++)
                     rotor_thr[i] = mix_throttle(n, i, base30,
                                                 longint'($signed(it.pitch_cmd)),
                                                 longint'($signed(it.roll_cmd)),
                                                 longint'($signed(it.yaw_cmd)));
               end
               for (int i = 0; i < n; i++)
                  if (rotor_dead[i])
                     rotor_thr[i] = '0;
               queue_all(n);
            end
            ACT_TRIM: begin
               for (int i = 0; i < n; i++) begin
                  rotor_dead[i] = 1'b0;
                  rotor_thr[i]  = fw_cfg ? HALF_Q15 : hov;
               end
               queue_all(n);
            end
            default: begin
               if (tgt >= n) begin
                  reports_due.push_back(report(tgt, '0, 1'b0, 1'b0, 1'b1));
               end else begin
                  if (it.action == ACT_KILL) begin
                     rotor_dead[tgt] = 1'b1;
                     rotor_thr[tgt]  = '0;
                  end else begin
                     rotor_dead[tgt] = 1'b0;
                     rotor_thr[tgt]  = thr;
                  end
                  reports_due.push_back(report(tgt, rotor_thr[tgt], rotor_dead[tgt],
                                               1'b1, 1'b1));
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (reports_due.size() == 0) begin
            $display("%0t: report with none expected, got rotor %0d throttle %0d",
                     $time, got.rotor_number, got.rotor_throttle);
            errors++;
            return;
         end
         want = reports_due.pop_front();
         compare_field("rotor_number", want.rotor_number, got.rotor_number);
         compare_field("rotor_throttle", want.rotor_throttle, got.rotor_throttle);
         compare_field("rotor_killed", want.rotor_killed, got.rotor_killed);
         compare_field("index_ok", want.index_ok, got.index_ok);
         compare_field("last", want.last, got.last);
      endfunction

      function int pending();
         return reports_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   rotor_report_board board;
   // rsp_calm: hold rsp_stall low while settling before register writes
   // tail_run: final stretch of the run, no idling on either side
   bit rsp_calm = 1'b0;
   bit tail_run = 1'b0;

   multirotor_motor_mixer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run; the slowest legal run is far shorter than this
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Observe all three channels in one place so that register writes, item
   // acceptance and report checks are always applied in the same order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            board.note_item(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_data);
      end
   end

   // Stall the report channel in bursts of random length, separated by
   // short gaps or long free stretches.
   initial begin
      int   stall_run, free_run;
      logic hold;
      stall_run = 0;
      free_run  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || rsp_calm || tail_run) begin
            hold      = 1'b0;
            stall_run = 0;
         end else if (stall_run > 0) begin
            hold = 1'b1;
            stall_run--;
         end else if (free_run > 0) begin
            hold = 1'b0;
            free_run--;
         end else begin
            hold      = 1'b1;
            stall_run = $urandom_range(1, 16) - 1;
            free_run  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
         end
         rsp_stall <= hold;
      end
   end

   // Present one item and hold it until the mixer takes it; leave valid high
   // so back-to-back items go out without a bubble.
   task automatic send_item(req_type it);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding rotor report
   task automatic wait_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reprogram all registers once the mixer is idle. Items with no report
   // (zero rotors) may still be in flight, so let the pipeline drain with
   // the report channel unstalled before touching the registers.
   task automatic set_mode(logic [3:0] rotors, logic [15:0] hover, logic fw);
      wait_reports();
      rsp_calm = 1'b1;
      repeat (40) @(posedge clock);
      write_reg(CSR_NUM_ROTORS, {12'd0, rotors});
      write_reg(CSR_HOVER, hover);
      write_reg(CSR_FIXED_WING, {15'd0, fw});
      rsp_calm = 1'b0;
   endtask

   function automatic req_type mk(logic [1:0] act, logic [15:0] thr, logic [15:0] p,
                                  logic [15:0] r, logic [15:0] y, logic [2:0] tgt);
      req_type it;
      it.action       = act;
      it.throttle_cmd = thr;
      it.pitch_cmd    = p;
      it.roll_cmd     = r;
      it.yaw_cmd      = y;
      it.target_rotor = tgt;
      return it;
   endfunction

   // Mix of full-scale, small and fully random stick positions
   function automatic logic [15:0] rand_stick();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3:    return 16'($urandom_range(0, 8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_item();
      int          pick;
      logic [1:0]  act;
      logic [15:0] thr;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         act = ACT_APPLY;
      else if (pick < 65)
         act = ACT_KILL;
      else if (pick < 82)
         act = ACT_RESTORE;
      else
         act = ACT_TRIM;
      case ($urandom_range(0, 9))
         0:       thr = 16'd0;
         1:       thr = ONE_Q15;
         2:       thr = 16'($urandom);
         default: thr = 16'($urandom_range(0, 32768));
      endcase
      return mk(act, thr, rand_stick(), rand_stick(), rand_stick(),
                3'($urandom_range(0, 7)));
   endfunction

   task automatic random_items(int count);
      for (int k = 0; k < count; k++) begin
         if (!tail_run && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 16));
         send_item(rand_item());
      end
   endtask

   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NUM_ROTORS;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: four rotors, half hover, rotor mixing
      send_item(mk(ACT_TRIM, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_APPLY, ONE_Q15, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_APPLY, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 3'd7));
      send_item(mk(ACT_APPLY, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 3'd0));
      send_item(mk(ACT_APPLY, HALF_Q15, 16'd0, 16'd0, 16'h7FFF, 3'd0));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd2));
      // killed rotor must stay at zero through a mix
      send_item(mk(ACT_APPLY, 16'd20000, 16'd1000, 16'hFC18, 16'd500, 3'd0));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd7));
      send_item(mk(ACT_RESTORE, 16'hFFFF, 16'd0, 16'd0, 16'd0, 3'd2));
      send_item(mk(ACT_RESTORE, 16'd1234, 16'd0, 16'd0, 16'd0, 3'd4));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_TRIM, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));

      // Fixed wing: only rotor 0 follows the throttle, trim goes to half
      set_mode(4'd5, 16'd0, 1'b1);
      send_item(mk(ACT_APPLY, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_APPLY, 16'd1000, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_RESTORE, 16'd12345, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_TRIM, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));

      // Zero rotors: apply and trim report nothing, every index is invalid
      set_mode(4'd0, ONE_Q15, 1'b0);
      send_item(mk(ACT_APPLY, ONE_Q15, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_TRIM, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
      send_item(mk(ACT_RESTORE, ONE_Q15, 16'd0, 16'd0, 16'd0, 3'd3));

      // Oversized count and hover saturate
      set_mode(4'd15, 16'hFFFF, 1'b0);
      send_item(mk(ACT_APPLY, ONE_Q15, 16'h8000, 16'h8000, 16'h8000, 3'd0));
      send_item(mk(ACT_KILL, 16'd0, 16'd0, 16'd0, 16'd0, 3'd7));
      send_item(mk(ACT_APPLY, 16'd8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0));

      // Random phases, extreme settings first
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       set_mode(4'd8, ONE_Q15, 1'b0);
            1:       set_mode(4'd1, 16'd0, 1'b0);
            2:       set_mode(4'd0, HALF_Q15, 1'b0);
            3:       set_mode(4'd15, 16'hFFFF, 1'b0);
            4:       set_mode(4'd3, 16'($urandom), 1'b1);
            default: set_mode(4'($urandom_range(1, 8)), 16'($urandom_range(0, 32768)),
                              $urandom_range(0, 3) == 0);
         endcase
         if (ph == 9)
            tail_run = 1'b1;
         if (ph == 5) begin
            // hold the sender until the mixer has fully caught up
            random_items(14);
            wait_reports();
            random_items(14);
         end else begin
            random_items((ph == 2) ? 10 : 28);
         end
      end

      wait_reports();
      repeat (30) @(posedge clock);
      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rmm_pkg.sv
rtl/core/rmm_front.sv
rtl/core/rmm_queue.sv
rtl/core/rmm_back.sv
rtl/core/multirotor_motor_mixer_unit.sv
tb/tb_multirotor_motor_mixer_unit.sv
